@@ rtl/core/radar_frame_parser_defines.svh @@
// Assertion macros shared by the frame parser RTL.
// Depends on nothing; the asserting modules must have clk and rst in scope.
`ifndef RADAR_FRAME_PARSER_DEFINES_SVH
`define RADAR_FRAME_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on the rising clock edge outside reset.
`define RFP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame parser check failed");
// Next-cycle implication, sampled on the rising clock edge outside reset.
`define RFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame parser check failed");
`else
`define RFP_ASSERT_NOW(lbl, ante, cons)
`define RFP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/core/rfp_pkg.sv @@
// Shared constants and the result type of the radar frame parser.
// Used by rfp_core and radar_frame_parser; depends on nothing.
package rfp_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'hAA;
  localparam logic [7:0] ID_RANGE  = 8'h0C;
  localparam logic [7:0] ID_ROLL   = 8'h0B;

  // Frame positions that carry meaning.
  localparam logic [3:0] POS_FIRST_BODY = 4'd2;
  localparam logic [3:0] POS_SUM_FIRST  = 4'd4;
  localparam logic [3:0] POS_ROLL       = 4'd5;
  localparam logic [3:0] POS_RANGE_HI   = 4'd6;
  localparam logic [3:0] POS_RANGE_LO   = 4'd7;
  localparam logic [3:0] POS_LAST_BODY  = 4'd10;

  localparam logic KIND_RANGE = 1'b0;
  localparam logic KIND_ROLL  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] range_cm;
    logic [7:0]  roll_value;
  } result_t;

endpackage

@@ rtl/core/rfp_core.sv @@
// Frame parsing state machine: sync hunt, body capture, running checksum
// and result decode for one byte per step. Depends on rfp_pkg.
`include "radar_frame_parser_defines.svh"

module rfp_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  output logic             hit,
  output rfp_pkg::result_t result
);

  localparam logic [1:0] PH_HUNT  = 2'd0;
  localparam logic [1:0] PH_SYNC1 = 2'd1;
  localparam logic [1:0] PH_BODY  = 2'd2;
  localparam logic [1:0] PH_CHECK = 2'd3;

  logic [1:0] phase, phase_next;
  logic [3:0] pos, pos_next;

  // Only the frame bytes that are ever read are kept, plus the running sum.
  logic [7:0] frame_id;
  logic [7:0] roll_byte;
  logic [7:0] range_hi;
  logic [7:0] range_lo;
  logic [7:0] sum;

  logic store;

  always_comb begin
    phase_next = phase;
    pos_next   = pos;
    store      = 1'b0;
    hit        = 1'b0;
    result     = '0;
    case (phase)
      PH_SYNC1: begin
        if (rx_byte == rfp_pkg::SYNC_BYTE) begin
          phase_next = PH_BODY;
          pos_next   = rfp_pkg::POS_FIRST_BODY;
        end else begin
          phase_next = PH_HUNT;
          pos_next   = 4'd0;
        end
      end
      PH_BODY: begin
        store    = 1'b1;
        pos_next = pos + 4'd1;
        if (pos == rfp_pkg::POS_LAST_BODY) begin
          phase_next = PH_CHECK;
        end
      end
      PH_CHECK: begin
        if (rx_byte == sum) begin
          if (frame_id == rfp_pkg::ID_RANGE) begin
            hit             = 1'b1;
            result.kind     = rfp_pkg::KIND_RANGE;
            result.range_cm = {range_hi, range_lo};
          end else if (frame_id == rfp_pkg::ID_ROLL) begin
            hit               = 1'b1;
            result.kind       = rfp_pkg::KIND_ROLL;
            result.roll_value = roll_byte;
          end
        end
        phase_next = PH_HUNT;
        pos_next   = 4'd0;
      end
      default: begin
        if (rx_byte == rfp_pkg::SYNC_BYTE) begin
          phase_next = PH_SYNC1;
          pos_next   = 4'd1;
        end else begin
          phase_next = PH_HUNT;
          pos_next   = 4'd0;
        end
      end
    endcase
    if (!step) begin
      hit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      pos   <= 4'd0;
    end else if (step) begin
      phase <= phase_next;
      pos   <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && store) begin
      if (pos == rfp_pkg::POS_FIRST_BODY) begin
        frame_id <= rx_byte;
      end
      if (pos == rfp_pkg::POS_ROLL) begin
        roll_byte <= rx_byte;
      end
      if (pos == rfp_pkg::POS_RANGE_HI) begin
        range_hi <= rx_byte;
      end
      if (pos == rfp_pkg::POS_RANGE_LO) begin
        range_lo <= rx_byte;
      end
      // The checksum covers positions 4 to 10 and wraps at eight bits.
      if (pos == rfp_pkg::POS_SUM_FIRST) begin
        sum <= rx_byte;
      end else if (pos > rfp_pkg::POS_SUM_FIRST) begin
        sum <= sum + rx_byte;
      end
    end
  end

  `RFP_ASSERT_NOW(a_hit_only_on_check, hit, step && phase == PH_CHECK)
  `RFP_ASSERT_NOW(a_body_pos_range, phase == PH_BODY,
                  pos >= rfp_pkg::POS_FIRST_BODY && pos <= rfp_pkg::POS_LAST_BODY)
  `RFP_ASSERT_NEXT(a_last_body_to_check,
                   step && phase == PH_BODY && pos == rfp_pkg::POS_LAST_BODY,
                   phase == PH_CHECK)

endmodule

@@ rtl/core/radar_frame_parser.sv @@
// Top level of the radar frame parser: input byte register, parser core
// and output result register. Depends on rfp_pkg and rfp_core.
//
// Usage: the radar's received bytes enter on the s_axis stream, one byte
// per word. The block hunts for two 0xAA sync bytes, captures frame
// positions 2 to 10 and checks the twelfth byte against the 8-bit sum of
// positions 4 to 10. A good frame with id 0x0C gives a range word
// (m_axis_tuser = 0), one with id 0x0B a roll-count word (m_axis_tuser = 1);
// bad or other frames give nothing and the hunt restarts.
// Throughput is one byte per cycle while the output register is free,
// set by the combinational parser step between the input register and
// the output register. A result is taken into the output register from
// the checksum byte held in the input register; while the output
// register stays full, that byte waits in the input register.
// Reset clears the parser to hunting and empties both registers.
// When the receiver stalls, the result word holds; the input register
// still advances while the output register is empty or being drained, so
// one byte can wait in the input register before s_axis_tready drops.
`include "radar_frame_parser_defines.svh"

module radar_frame_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [15:0] range_cm, [23:16] roll_value
  output logic        m_axis_tuser   // [0] result_kind
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       out_free;
  logic       step;

  logic             hit;
  rfp_pkg::result_t core_result;
  rfp_pkg::result_t out_result;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign step          = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  rfp_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (in_byte),
    .hit     (hit),
    .result  (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= hit;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      out_result <= core_result;
    end
  end

  assign m_axis_tdata = {out_result.roll_value, out_result.range_cm};
  assign m_axis_tuser = out_result.kind;

  `RFP_ASSERT_NEXT(a_input_holds_on_stall, in_valid && !out_free,
                   in_valid && $stable(in_byte))
  `RFP_ASSERT_NEXT(a_output_drains, m_axis_tvalid && m_axis_tready && !hit,
                   !m_axis_tvalid)
  `RFP_ASSERT_NOW(a_roll_has_no_range,
                  m_axis_tvalid && m_axis_tuser == rfp_pkg::KIND_ROLL,
                  m_axis_tdata[15:0] == 16'd0)

endmodule
